// File: src/twq_pkg.sv
// twq_pkg: shared types and constants for the timed wakeup queue.
// No dependencies.
package twq_pkg;

  localparam int WAIT_DEPTH  = 16;
  localparam int READY_DEPTH = 16;
  localparam int WAIT_CW     = $clog2(WAIT_DEPTH + 1);
  localparam int READY_CW    = $clog2(READY_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_ENQ    = 2'd0,
    OP_NOTIFY = 2'd1,
    OP_POP    = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // command broadcast to every wait cell
  typedef enum logic [2:0] {
    WC_HOLD   = 3'd0,
    WC_INSERT = 3'd1,
    WC_SHIFTL = 3'd2,
    WC_COMPACT = 3'd3
  } wcmd_t;

  typedef struct packed {
    wcmd_t       cmd;
    logic [15:0] id;
    logic [31:0] wake;
    logic [31:0] now;
  } wctl_t;

  // saturate a count to 5 bits
  function automatic logic [4:0] sat5(input logic [8:0] v);
    sat5 = (v > 9'd31) ? 5'd31 : v[4:0];
  endfunction

endpackage

// File: src/twq_if.sv
// twq_if: valid/ready channel carrying one word of payload type.
// Depends on nothing.
interface twq_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// File: src/twq_cell.sv
// twq_cell: one slot of the sorted wait chain.
// Depends on twq_pkg.
module twq_cell (
  input  logic               clk,
  input  twq_pkg::wctl_t     ctl,
  input  logic               live,       // slot index below fill
  input  logic               left_ins,   // insertion lands left of here
  input  logic [15:0]        left_id,
  input  logic [31:0]        left_wake,
  input  logic [15:0]        right_id,
  input  logic [31:0]        right_wake,
  input  logic               right_shift,// take right neighbor (compact/shift)
  output logic               ins_here,   // insertion lands at or left of here
  output logic [15:0]        id_o,
  output logic [31:0]        wake_o
);
  logic [15:0] id_r, id_nxt;
  logic [31:0] wake_r, wake_nxt;
  logic        later;
  logic        own;

  // new item goes before this slot when strictly sooner, or slot empty;
  // only the first such slot in the chain takes it
  assign later    = (ctl.wake - ctl.now) < (wake_r - ctl.now);
  assign own      = !live || later;
  assign ins_here = left_ins || own;

  always_comb begin
    id_nxt   = id_r;
    wake_nxt = wake_r;
    case (ctl.cmd)
      twq_pkg::WC_INSERT: begin
        if (left_ins) begin
          id_nxt = left_id; wake_nxt = left_wake;
        end else if (own) begin
          id_nxt = ctl.id; wake_nxt = ctl.wake;
        end
      end
      twq_pkg::WC_SHIFTL, twq_pkg::WC_COMPACT: begin
        if (right_shift) begin
          id_nxt = right_id; wake_nxt = right_wake;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    id_r   <= id_nxt;
    wake_r <= wake_nxt;
  end

  assign id_o   = id_r;
  assign wake_o = wake_r;
endmodule

// File: src/twq_ready.sv
// twq_ready: ready FIFO as a shift chain; head in slot 0.
// Depends on twq_pkg.
module twq_ready (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [15:0]                  push_id,
  input  logic                         pop,
  input  logic                         del,       // drop one slot by index
  input  logic [$clog2(twq_pkg::READY_DEPTH)-1:0] del_idx,
  input  logic [$clog2(twq_pkg::READY_DEPTH)-1:0] rd_idx,
  output logic [15:0]                  rd_id,
  output logic [15:0]                  head_id,
  output logic [twq_pkg::READY_CW-1:0] fill
);
  localparam int D  = twq_pkg::READY_DEPTH;
  localparam int IW = $clog2(D);

  logic [15:0]               q_r [D];
  logic [15:0]               q_nxt [D];
  logic [twq_pkg::READY_CW-1:0] fill_r, fill_nxt;

  // shift or append; each slot only sees its neighbor
  always_comb begin
    fill_nxt = fill_r;
    for (int i = 0; i < D; i++) q_nxt[i] = q_r[i];
    if (push) begin
      for (int i = 0; i < D; i++)
        if (fill_r[IW-1:0] == IW'(i)) q_nxt[i] = push_id;
      fill_nxt = fill_r + 1'b1;
    end else if (pop || del) begin
      for (int i = 0; i < D - 1; i++)
        if (pop || IW'(i) >= del_idx) q_nxt[i] = q_r[i+1];
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < D; i++) q_r[i] <= q_nxt[i];
    if (!rst_n) fill_r <= '0;
    else fill_r <= fill_nxt;
  end

  assign rd_id   = q_r[rd_idx];
  assign head_id = q_r[0];
  assign fill    = fill_r;

  push_bound: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> fill_r < twq_pkg::READY_CW'(D)) else $error("ready overflow");
  pop_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (pop || del) |-> fill_r != '0) else $error("ready underflow");
  one_op: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && (pop || del))) else $error("ready conflict");
endmodule

// File: src/timed_wakeup_queue.sv
// timed_wakeup_queue: top level; sorted wait chain of cells plus ready FIFO.
// Depends on twq_pkg, twq_if, twq_cell, twq_ready.
//
//  channel | dir | payload
//  in      | in  | operation[1:0], item_id[15:0], time_value[31:0]
//  out     | out | status, popped_item, moved_count, waiting_count, ready_count
//
// Sequence: enqueue and pop finish in the execute state and register their
// result; notify moves due heads one at a time in the notify state; remove
// walks the wait chain, then the ready chain, slot by slot, each with an exit step.
// The per-step walk of the cell chain sets the rate; one word at a time.
// Reset clears fills, current time and control; cell contents need none.
// A held result waits in the output register; input is taken again once empty.
module timed_wakeup_queue (
  input logic clk,
  input logic rst_n,
  twq_if.sink   in_ch,
  twq_if.source out_ch
);
  localparam int WD  = twq_pkg::WAIT_DEPTH;
  localparam int RD  = twq_pkg::READY_DEPTH;
  localparam int WI  = $clog2(WD);
  localparam int RI  = $clog2(RD);
  localparam int WCW = twq_pkg::WAIT_CW;
  localparam int RCW = twq_pkg::READY_CW;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_EXEC = 5'b00010, S_NOTE = 5'b00100,
    S_RMW  = 5'b01000, S_RMR  = 5'b10000
  } state_t;

  state_t       st_r, st_nxt;
  twq_pkg::op_t op_r;
  logic [15:0]  id_r;
  logic [31:0]  tv_r, now_r;
  logic [WCW-1:0] wfill_r;
  logic [WCW:0]   widx_r;
  logic [RCW:0]   ridx_r;
  logic [8:0]     moved_r;
  logic           ovalid_r;
  logic [32:0]    odata_r;

  // cell chain wiring
  twq_pkg::wctl_t wctl;
  logic        ins  [WD];
  logic [15:0] cid  [WD];
  logic [31:0] cwk  [WD];
  logic        shf  [WD];

  logic        r_push, r_pop, r_del;
  logic [15:0] r_push_id, r_rd, r_head;
  logic [RCW-1:0] rfill;

  logic take;
  assign in_ch.ready = (st_r == S_IDLE) && !ovalid_r;
  assign take = in_ch.valid && in_ch.ready;

  logic rfull, head_due, wfull;
  assign rfull    = rfill == RCW'(RD);
  assign wfull    = wfill_r == WCW'(WD);
  assign head_due = (cwk[0] - now_r) <= (tv_r - now_r);

  genvar g;
  generate
    for (g = 0; g < WD; g++) begin : g_cell
      logic live;
      assign live = WCW'(g) < wfill_r;
      twq_cell u_cell (
        .clk(clk), .ctl(wctl), .live(live),
        .left_ins((g == 0) ? 1'b0 : ins[(g == 0) ? 0 : g-1]),
        .left_id(cid[(g == 0) ? 0 : g-1]), .left_wake(cwk[(g == 0) ? 0 : g-1]),
        .right_id(cid[(g == WD-1) ? g : g+1]),
        .right_wake(cwk[(g == WD-1) ? g : g+1]),
        .right_shift(shf[g]), .ins_here(ins[g]),
        .id_o(cid[g]), .wake_o(cwk[g]));
      // shift left from here onward for drop of head or removal slot
      assign shf[g] = (g != WD-1) &&
        ((wctl.cmd == twq_pkg::WC_SHIFTL) ||
         (wctl.cmd == twq_pkg::WC_COMPACT && (WCW+1)'(g) >= widx_r));
    end
  endgenerate

  twq_ready u_ready (
    .clk(clk), .rst_n(rst_n), .push(r_push), .push_id(r_push_id),
    .pop(r_pop), .del(r_del), .del_idx(ridx_r[RI-1:0]),
    .rd_idx(ridx_r[RI-1:0]), .rd_id(r_rd), .head_id(r_head), .fill(rfill));

  // sequencer
  logic fin;
  logic [WCW-1:0] wfill_nxt;
  always_comb begin
    st_nxt    = st_r;
    wctl      = '{cmd: twq_pkg::WC_HOLD, id: id_r, wake: tv_r, now: now_r};
    r_push    = 1'b0;
    r_push_id = id_r;
    r_pop     = 1'b0;
    r_del     = 1'b0;
    wfill_nxt = wfill_r;
    fin       = 1'b0;
    case (st_r)
      S_IDLE: if (take) st_nxt = S_EXEC;
      S_EXEC: begin
        case (op_r)
          twq_pkg::OP_ENQ: begin
            fin = 1'b1;
            if (tv_r == now_r) begin
              if (!rfull) r_push = 1'b1;
            end else if (!wfull) begin
              wctl.cmd  = twq_pkg::WC_INSERT;
              wfill_nxt = wfill_r + 1'b1;
            end
          end
          twq_pkg::OP_NOTIFY: st_nxt = S_NOTE;
          twq_pkg::OP_POP: begin
            fin = 1'b1;
            if (rfill != '0) r_pop = 1'b1;
          end
          default: st_nxt = S_RMW;
        endcase
      end
      S_NOTE: begin
        if (wfill_r != '0 && head_due && !rfull) begin
          r_push = 1'b1; r_push_id = cid[0];
          wctl.cmd = twq_pkg::WC_SHIFTL;
          wfill_nxt = wfill_r - 1'b1;
        end else fin = 1'b1;
      end
      S_RMW: begin
        if (widx_r >= (WCW+1)'(wfill_r)) st_nxt = S_RMR;
        else if (cid[widx_r[WI-1:0]] == id_r) begin
          wctl.cmd = twq_pkg::WC_COMPACT;
          wfill_nxt = wfill_r - 1'b1;
        end
      end
      S_RMR: begin
        if (ridx_r >= (RCW+1)'(rfill)) fin = 1'b1;
        else if (r_rd == id_r) r_del = 1'b1;
      end
      default: st_nxt = S_IDLE;
    endcase
    if (fin) st_nxt = S_IDLE;
  end

  logic [RCW-1:0] rfill_after;
  assign rfill_after = r_push ? rfill + 1'b1 : ((r_pop || r_del) ? rfill - 1'b1 : rfill);

  always_ff @(posedge clk) begin
    if (take) begin
      op_r <= twq_pkg::op_t'(in_ch.data[49:48]);
      id_r <= in_ch.data[47:32];
      tv_r <= in_ch.data[31:0];
    end
    if (!rst_n) begin
      st_r <= S_IDLE; wfill_r <= '0; now_r <= '0; ovalid_r <= 1'b0;
      widx_r <= '0; ridx_r <= '0; moved_r <= '0;
    end else begin
      st_r    <= st_nxt;
      wfill_r <= wfill_nxt;
      if (out_ch.valid && out_ch.ready) ovalid_r <= 1'b0;
      if (take) begin
        widx_r <= '0; ridx_r <= '0; moved_r <= '0;
      end
      if (r_push) moved_r <= moved_r + 1'b1;
      // advance scan only past kept slots
      if (st_r == S_RMW && wctl.cmd != twq_pkg::WC_COMPACT) widx_r <= widx_r + 1'b1;
      if (st_r == S_RMR && !r_del) ridx_r <= ridx_r + 1'b1;
      if (fin) begin
        logic [1:0] s;
        logic [15:0] p;
        logic [8:0] mv;
        s  = twq_pkg::ST_OK;
        p  = 16'd0;
        mv = moved_r + {8'd0, r_push};
        if (st_r == S_EXEC && op_r == twq_pkg::OP_ENQ && !r_push &&
            wctl.cmd != twq_pkg::WC_INSERT) s = twq_pkg::ST_FULL;
        if (st_r == S_EXEC && op_r == twq_pkg::OP_POP) begin
          if (r_pop) p = r_head; else s = twq_pkg::ST_EMPTY;
        end
        if (st_r == S_NOTE) begin
          now_r <= tv_r;
          if (wfill_r != '0 && head_due && rfull) s = twq_pkg::ST_FULL;
        end
        ovalid_r <= 1'b1;
        odata_r  <= {s, p, twq_pkg::sat5(mv),
                     twq_pkg::sat5(9'(wfill_nxt)), twq_pkg::sat5(9'(rfill_after))};
      end
    end
  end

  assign out_ch.valid = ovalid_r;
  assign out_ch.data  = odata_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> !in_ch.ready) else $error("input taken while result held");
  a_wfill: assert property (@(posedge clk) disable iff (!rst_n)
    wfill_r <= WCW'(WD)) else $error("wait fill out of range");
  a_ins: assert property (@(posedge clk) disable iff (!rst_n)
    wctl.cmd == twq_pkg::WC_INSERT |-> !wfull) else $error("insert into full store");
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> st_r == S_EXEC) else $error("item not started");
endmodule

// File: verif/timed_wakeup_queue_test.sv
// timed_wakeup_queue_test: self-checking testbench for the timed wakeup queue.
// Depends on twq_pkg, twq_if and the timed_wakeup_queue RTL; drives a directed
// table, then random operation mixes, and checks every result word in order.
module timed_wakeup_queue_test;
  timeunit 1ns;
  timeprecision 1ps;
  import twq_pkg::*;

  localparam int IN_W      = 50;
  localparam int OUT_W     = 33;
  localparam int RAND_OPS  = 600;
  localparam int CYC_LIMIT = 300000;

  typedef struct packed {
    op_t         op;
    logic [15:0] id;
    logic [31:0] tv;
  } cmd_word_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] popped;
    logic [4:0]  moved;
    logic [4:0]  waiting;
    logic [4:0]  ready;
  } rsp_word_t;

  typedef struct {
    cmd_word_t cmd;
    bit        typed;
    rsp_word_t rsp;
  } table_row_t;

  logic clk;
  logic rst_n;
  int   cycles;
  int   mismatches;
  int   rsp_seen;
  bit   hold_done;

  twq_if #(.W(IN_W))  in_ch();
  twq_if #(.W(OUT_W)) out_ch();

  timed_wakeup_queue u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // mirror of the queue state
  logic [31:0] mir_wake [WAIT_DEPTH];
  logic [15:0] mir_item [WAIT_DEPTH];
  int          mir_wfill;
  logic [15:0] mir_ready [READY_DEPTH];
  int          mir_rfill;
  logic [31:0] mir_now;

  rsp_word_t expected_rsp[$];

  // clock and cycle limit
  initial begin
    clk = 1'b0;
    cycles = 0;
    forever begin
      #5 clk = ~clk;
      if (clk) begin
        cycles++;
        if (cycles > CYC_LIMIT) begin
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  function automatic bit ready_append(logic [15:0] id);
    if (mir_rfill >= READY_DEPTH) return 1'b0;
    mir_ready[mir_rfill] = id;
    mir_rfill++;
    return 1'b1;
  endfunction

  // advance the mirror by one command and return the result word it implies
  function automatic rsp_word_t wakeup_step(cmd_word_t c);
    rsp_word_t   r;
    logic [31:0] gap;
    logic [31:0] passed;
    int          pos;
    int          w;
    r = '0;
    r.status = ST_OK;
    case (c.op)
      OP_ENQ: begin
        if (c.tv == mir_now) begin
          if (ready_append(c.id)) r.moved = 5'd1;
          else r.status = ST_FULL;
        end else if (mir_wfill >= WAIT_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // insert behind every entry of equal or smaller distance
          gap = c.tv - mir_now;
          pos = mir_wfill;
          for (int i = 0; i < mir_wfill; i++) begin
            if (gap < mir_wake[i] - mir_now) begin
              pos = i;
              break;
            end
          end
          for (int i = mir_wfill; i > pos; i--) begin
            mir_wake[i] = mir_wake[i-1];
            mir_item[i] = mir_item[i-1];
          end
          mir_wake[pos] = c.tv;
          mir_item[pos] = c.id;
          mir_wfill++;
        end
      end
      OP_NOTIFY: begin
        passed = c.tv - mir_now;
        while (mir_wfill > 0) begin
          if (mir_wake[0] - mir_now > passed) break;
          if (!ready_append(mir_item[0])) begin
            r.status = ST_FULL;
            break;
          end
          for (int i = 1; i < mir_wfill; i++) begin
            mir_wake[i-1] = mir_wake[i];
            mir_item[i-1] = mir_item[i];
          end
          mir_wfill--;
          r.moved++;
        end
        mir_now = c.tv;
      end
      OP_POP: begin
        if (mir_rfill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.popped = mir_ready[0];
          for (int i = 1; i < mir_rfill; i++) mir_ready[i-1] = mir_ready[i];
          mir_rfill--;
        end
      end
      default: begin
        // drop every copy of the id from both stores
        w = 0;
        for (int i = 0; i < mir_wfill; i++) begin
          if (mir_item[i] != c.id) begin
            mir_wake[w] = mir_wake[i];
            mir_item[w] = mir_item[i];
            w++;
          end
        end
        mir_wfill = w;
        w = 0;
        for (int i = 0; i < mir_rfill; i++) begin
          if (mir_ready[i] != c.id) begin
            mir_ready[w] = mir_ready[i];
            w++;
          end
        end
        mir_rfill = w;
      end
    endcase
    r.waiting = 5'(mir_wfill);
    r.ready   = 5'(mir_rfill);
    return r;
  endfunction

  function automatic table_row_t row(op_t op, logic [15:0] id, logic [31:0] tv,
                                     bit typed = 0, rsp_word_t rsp = '0);
    table_row_t t;
    t.cmd   = '{op: op, id: id, tv: tv};
    t.typed = typed;
    t.rsp   = rsp;
    return t;
  endfunction

  // offer one command word, hold it until accepted, record its result
  task automatic send_cmd(cmd_word_t c, bit typed, rsp_word_t rsp, bit may_idle);
    rsp_word_t p;
    while (may_idle && $urandom_range(99) < 31) @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.data  = c;
    forever begin
      @(posedge clk);
      if (in_ch.ready) break;
    end
    p = wakeup_step(c);
    expected_rsp.push_back(typed ? rsp : p);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  function automatic cmd_word_t random_cmd(int mode);
    cmd_word_t c;
    int        pick;
    pick = $urandom_range(99);
    case (mode)
      1:       c.op = pick < 70 ? OP_ENQ : pick < 80 ? OP_NOTIFY : pick < 90 ? OP_POP : OP_REMOVE;
      2:       c.op = pick < 45 ? OP_ENQ : pick < 90 ? OP_NOTIFY : pick < 93 ? OP_POP : OP_REMOVE;
      3:       c.op = pick < 20 ? OP_ENQ : pick < 35 ? OP_NOTIFY : pick < 90 ? OP_POP : OP_REMOVE;
      default: c.op = pick < 35 ? OP_ENQ : pick < 60 ? OP_NOTIFY : pick < 85 ? OP_POP : OP_REMOVE;
    endcase
    c.id = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(7));
    pick = $urandom_range(19);
    if (c.op == OP_ENQ)
      c.tv = pick < 2 ? $urandom : pick < 5 ? mir_now : mir_now + $urandom_range(1, 20);
    else if (c.op == OP_NOTIFY)
      c.tv = pick < 1 ? $urandom : mir_now + $urandom_range(0, 12);
    else
      c.tv = $urandom;
    return c;
  endfunction

  // stimulus
  initial begin
    table_row_t dir_rows[$];
    rsp_word_t  z;
    int         mode;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    mir_wfill = 0;
    mir_rfill = 0;
    mir_now   = '0;
    z = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // queue empty after reset, due-now enqueue, then pop of the extreme id
    dir_rows.push_back(row(OP_POP, 16'h1234, 32'h0, 1,
                           '{ST_EMPTY, 16'h0, 5'd0, 5'd0, 5'd0}));
    dir_rows.push_back(row(OP_ENQ, 16'hFFFF, 32'h0, 1,
                           '{ST_OK, 16'h0, 5'd1, 5'd0, 5'd1}));
    dir_rows.push_back(row(OP_POP, 16'h0, 32'hFFFF_FFFF, 1,
                           '{ST_OK, 16'hFFFF, 5'd0, 5'd0, 5'd0}));
    // equal distances keep arrival order; farthest wake time
    dir_rows.push_back(row(OP_ENQ, 16'd1, 32'd5));
    dir_rows.push_back(row(OP_ENQ, 16'd2, 32'd5));
    dir_rows.push_back(row(OP_ENQ, 16'd3, 32'hFFFF_FFFF));
    dir_rows.push_back(row(OP_ENQ, 16'd0, 32'd3));
    dir_rows.push_back(row(OP_REMOVE, 16'd7, 32'h0, 1,
                           '{ST_OK, 16'h0, 5'd0, 5'd4, 5'd0}));
    dir_rows.push_back(row(OP_NOTIFY, 16'hFFFF, 32'd5));
    dir_rows.push_back(row(OP_REMOVE, 16'd1, 32'h0));
    // notify back in time wraps around and passes everything
    dir_rows.push_back(row(OP_NOTIFY, 16'h0, 32'd2));
    dir_rows.push_back(row(OP_ENQ, 16'hAAAA, 32'h5555_5555));
    dir_rows.push_back(row(OP_ENQ, 16'h5555, 32'hAAAA_AAAA));
    dir_rows.push_back(row(OP_ENQ, 16'hAAAA, 32'h0000_0010));
    dir_rows.push_back(row(OP_REMOVE, 16'hAAAA, 32'h0));
    dir_rows.push_back(row(OP_NOTIFY, 16'h0, 32'hAAAA_AAAA));
    repeat (4) dir_rows.push_back(row(OP_POP, 16'h0, 32'h0));
    dir_rows.push_back(row(OP_NOTIFY, 16'h0, 32'hFFFF_FFFF));

    foreach (dir_rows[i]) send_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].rsp, 1);

    // random mixes, mode changes every few dozen words
    mode = 0;
    for (int n = 0; n < RAND_OPS; n++) begin
      if (n % 50 == 0) mode = $urandom_range(3);
      // pause until the block has drained, then resume on a falling edge
      if (n == 450) begin
        wait (expected_rsp.size() == 0);
        @(negedge clk);
      end
      send_cmd(random_cmd(mode), 0, z, !(n >= 100 && n < 180));
    end

    wait (expected_rsp.size() == 0);
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // result side ready, with a long hold-off once 300 result words are seen
  initial begin
    int quiet;
    out_ch.ready = 1'b0;
    hold_done = 0;
    forever begin
      @(negedge clk);
      if (!hold_done && rsp_seen >= 300) begin
        hold_done = 1;
        out_ch.ready = 1'b0;
        quiet = 0;
        while (quiet < 300) begin
          @(negedge clk);
          quiet++;
        end
      end
      if (rsp_seen >= 120 && rsp_seen < 200) out_ch.ready = 1'b1;
      else out_ch.ready = ($urandom_range(99) >= 31);
    end
  end

  // compare each accepted result word with the oldest expectation
  initial begin
    rsp_word_t got;
    rsp_word_t exp;
    mismatches = 0;
    rsp_seen = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        rsp_seen++;
        if (expected_rsp.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %p", got);
        end else begin
          exp = expected_rsp.pop_front();
          if (got.status !== exp.status || got.popped !== exp.popped ||
              got.moved !== exp.moved || got.waiting !== exp.waiting ||
              got.ready !== exp.ready) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d mismatch: expected %p, got %p", rsp_seen, exp, got);
          end
        end
      end
    end
  end

endmodule
